@@ src/htw_pkg.sv @@
// shared constants, types and codes of the hashed timing wheel
package htw_pkg;

	localparam int NUM_TIMERS = 64;
	localparam int ID_W       = 6;
	localparam int SLOTS      = 1024;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int TMO_W      = 20;
	localparam int RND_W      = TMO_W - SLOT_W;
	localparam int IVL_W      = 16;
	localparam int OP_W       = 2;

	localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
	localparam logic [OP_W-1:0] OP_START  = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [IVL_W-1:0] IVL_RESET = 16'd1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIVS,
		S_DIVW,
		S_WRST,
		S_REM,
		S_ACK,
		S_SRD,
		S_SEV,
		S_SDIVW,
		S_SWR,
		S_SEND
	} state_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [RND_W-1:0]  rounds;
		logic              per;
		logic [TMO_W-1:0]  period;
	} entry_t;

	typedef struct packed {
		logic in_ready;
		logic latch_in;
		logic div_start;
		logic div_src_period;
		logic ram_rd;
		logic wr_start;
		logic wr_dec;
		logic wr_rearm;
		logic arm_clr_in;
		logic arm_clr_t;
		logic t_clr;
		logic t_inc;
		logic pend_clr;
		logic pend_set;
		logic emit_ack;
		logic emit_mid;
		logic emit_final;
		logic cur_inc;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] in_op;
		logic            armed_t;
		logic            slot_match;
		logic            rounds_nz;
		logic            periodic;
		logic            div_done;
		logic            out_free;
		logic            t_last;
		logic            pend_valid;
	} sts_t;

endpackage

@@ src/htw_if.sv @@
// channel interfaces: request, response and configuration write
interface htw_req_if;
	logic                          valid;
	logic                          ready;
	logic [htw_pkg::OP_W-1:0]      op;
	logic [htw_pkg::ID_W-1:0]      timer_id;
	logic [htw_pkg::TMO_W-1:0]     timeout;
	logic                          periodic;
	modport source (output valid, op, timer_id, timeout, periodic, input ready);
	modport sink (input valid, op, timer_id, timeout, periodic, output ready);
endinterface

interface htw_rsp_if;
	logic                     valid;
	logic                     ready;
	logic                     fired;
	logic [htw_pkg::ID_W-1:0] fired_id;
	logic                     last;
	modport source (output valid, fired, fired_id, last, input ready);
	modport sink (input valid, fired, fired_id, last, output ready);
endinterface

interface htw_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [htw_pkg::IVL_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ src/hashed_timing_wheel.sv @@
// top level of the hashed timing wheel
//
// channel  dir  payload                              handshake
// req      in   op, timer_id, timeout, periodic      valid/ready
// rsp      out  fired, fired_id, last                valid/ready
// cfg      in   data (slot_interval)                 valid/ready, ready always high
//
// a start runs the 20-step divider, writes the table entry and acks; a remove clears the armed
// bit and acks, an unused op only acks; a tick scans all timers, reads each armed one from the
// table ram, and re-arms each periodic timer that fires through the divider
// reset clears the armed bits, the wheel position and the interval to 1; no clearing pass
// a stalled rsp holds the scan only where another result has to be written out
module hashed_timing_wheel (
	input logic     clk,
	input logic     arst_n,
	htw_req_if.sink   req,
	htw_rsp_if.source rsp,
	htw_cfg_if.sink   cfg
);

	htw_pkg::cmd_t   cmd;
	htw_pkg::sts_t   sts;
	htw_pkg::state_t state;

	assign cfg.ready = 1'b1;
	assign req.ready = cmd.in_ready;

	htw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.sts       (sts),
		.cmd       (cmd),
		.state     (state)
	);

	htw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_op     (req.op),
		.in_id     (req.timer_id),
		.in_tmo    (req.timeout),
		.in_per    (req.periodic),
		.cfg_wr    (cfg.valid),
		.cfg_data  (cfg.data),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_fired (rsp.fired),
		.out_id    (rsp.fired_id),
		.out_last  (rsp.last)
	);

	a_ack_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.fired |-> rsp.last && rsp.fired_id == '0)
		else $error("acknowledgment without last or with nonzero id");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.op == htw_pkg::OP_TICK |=> !req.ready)
		else $error("request taken during a tick scan");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state == htw_pkg::S_DIVW || state == htw_pkg::S_SDIVW)
		else $error("divider finished outside a wait state");

endmodule

@@ src/htw_ram.sv @@
// generic single-write, single-read ram with registered read
module htw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ src/htw_div.sv @@
// restoring divider, one quotient bit per cycle
module htw_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [htw_pkg::TMO_W-1:0] dividend,
	input  logic [htw_pkg::IVL_W-1:0] divisor,
	output logic [htw_pkg::TMO_W-1:0] quo,
	output logic                      done
);

	localparam int CNT_W = $clog2(htw_pkg::TMO_W + 1);

	logic [CNT_W-1:0]          cnt_q;
	logic                      done_q;
	logic [htw_pkg::IVL_W-1:0] rem_q;
	logic [htw_pkg::IVL_W-1:0] div_q;
	logic [htw_pkg::TMO_W-1:0] quo_q;
	logic [htw_pkg::IVL_W:0]   rem_sh;
	logic                      ge;
	logic [htw_pkg::IVL_W:0]   rem_sub;

	assign rem_sh  = {rem_q, quo_q[htw_pkg::TMO_W-1]};
	assign ge      = rem_sh >= {1'b0, div_q};
	assign rem_sub = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(htw_pkg::TMO_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? rem_sub[htw_pkg::IVL_W-1:0] : rem_sh[htw_pkg::IVL_W-1:0];
			quo_q <= {quo_q[htw_pkg::TMO_W-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

@@ src/htw_ctrl.sv @@
// controller state machine: sequences starts, removes and the tick scan
module htw_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  htw_pkg::sts_t   sts,
	output htw_pkg::cmd_t   cmd,
	output htw_pkg::state_t state
);

	htw_pkg::state_t state_q;
	htw_pkg::state_t state_d;
	logic            fire;

	assign fire  = sts.slot_match && !sts.rounds_nz;
	assign state = state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= htw_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			htw_pkg::S_IDLE: begin
				if (req_valid) begin
					unique case (sts.in_op)
						htw_pkg::OP_TICK:   state_d = htw_pkg::S_SRD;
						htw_pkg::OP_START:  state_d = htw_pkg::S_DIVS;
						htw_pkg::OP_REMOVE: state_d = htw_pkg::S_REM;
						default:            state_d = htw_pkg::S_ACK;
					endcase
				end
			end
			htw_pkg::S_DIVS: state_d = htw_pkg::S_DIVW;
			htw_pkg::S_DIVW: if (sts.div_done) state_d = htw_pkg::S_WRST;
			htw_pkg::S_WRST: state_d = htw_pkg::S_ACK;
			htw_pkg::S_REM:  state_d = htw_pkg::S_ACK;
			htw_pkg::S_ACK:  if (sts.out_free) state_d = htw_pkg::S_IDLE;
			htw_pkg::S_SRD: begin
				if (sts.armed_t) begin
					state_d = htw_pkg::S_SEV;
				end else if (sts.t_last) begin
					state_d = htw_pkg::S_SEND;
				end
			end
			htw_pkg::S_SEV: begin
				if (fire) begin
					if (!sts.pend_valid || sts.out_free) begin
						if (sts.periodic) begin
							state_d = htw_pkg::S_SDIVW;
						end else begin
							state_d = sts.t_last ? htw_pkg::S_SEND : htw_pkg::S_SRD;
						end
					end
				end else begin
					state_d = sts.t_last ? htw_pkg::S_SEND : htw_pkg::S_SRD;
				end
			end
			htw_pkg::S_SDIVW: if (sts.div_done) state_d = htw_pkg::S_SWR;
			htw_pkg::S_SWR:   state_d = sts.t_last ? htw_pkg::S_SEND : htw_pkg::S_SRD;
			htw_pkg::S_SEND:  if (sts.out_free) state_d = htw_pkg::S_IDLE;
			default:          state_d = htw_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			htw_pkg::S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (req_valid) begin
					cmd.latch_in = 1'b1;
					cmd.t_clr    = 1'b1;
					cmd.pend_clr = 1'b1;
				end
			end
			htw_pkg::S_DIVS: cmd.div_start = 1'b1;
			htw_pkg::S_WRST: cmd.wr_start = 1'b1;
			htw_pkg::S_REM:  cmd.arm_clr_in = 1'b1;
			htw_pkg::S_ACK:  cmd.emit_ack = sts.out_free;
			htw_pkg::S_SRD: begin
				if (sts.armed_t) begin
					cmd.ram_rd = 1'b1;
				end else if (!sts.t_last) begin
					cmd.t_inc = 1'b1;
				end
			end
			htw_pkg::S_SEV: begin
				if (fire) begin
					if (!sts.pend_valid || sts.out_free) begin
						cmd.emit_mid = sts.pend_valid;
						cmd.pend_set = 1'b1;
						if (sts.periodic) begin
							cmd.div_start      = 1'b1;
							cmd.div_src_period = 1'b1;
						end else begin
							cmd.arm_clr_t = 1'b1;
							cmd.t_inc     = !sts.t_last;
						end
					end
				end else begin
					// armed but in another slot, or still has rounds to go
					cmd.wr_dec = sts.slot_match;
					cmd.t_inc  = !sts.t_last;
				end
			end
			htw_pkg::S_SWR: begin
				cmd.wr_rearm = 1'b1;
				cmd.t_inc    = !sts.t_last;
			end
			htw_pkg::S_SEND: begin
				cmd.emit_final = sts.out_free;
				cmd.cur_inc    = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

@@ src/htw_dp.sv @@
// datapath: timer table, armed bits, divider, wheel position and result register
module htw_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  htw_pkg::cmd_t             cmd,
	output htw_pkg::sts_t             sts,
	input  logic [htw_pkg::OP_W-1:0]  in_op,
	input  logic [htw_pkg::ID_W-1:0]  in_id,
	input  logic [htw_pkg::TMO_W-1:0] in_tmo,
	input  logic                      in_per,
	input  logic                      cfg_wr,
	input  logic [htw_pkg::IVL_W-1:0] cfg_data,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic                      out_fired,
	output logic [htw_pkg::ID_W-1:0]  out_id,
	output logic                      out_last
);

	localparam int EW = $bits(htw_pkg::entry_t);

	logic [htw_pkg::IVL_W-1:0]      ivl_q;
	logic [htw_pkg::ID_W-1:0]       id_q;
	logic [htw_pkg::TMO_W-1:0]      tmo_q;
	logic                           per_q;
	logic [htw_pkg::NUM_TIMERS-1:0] armed_q;
	logic [htw_pkg::ID_W-1:0]       t_q;
	logic [htw_pkg::SLOT_W-1:0]     cur_q;
	logic                           pend_v_q;
	logic [htw_pkg::ID_W-1:0]       pend_q;
	logic                           ov_q;
	logic                           of_q;
	logic [htw_pkg::ID_W-1:0]       oid_q;
	logic                           ol_q;

	htw_pkg::entry_t            rd_ent;
	htw_pkg::entry_t            wr_ent;
	logic [EW-1:0]              rd_raw;
	logic                       wr_en;
	logic [htw_pkg::ID_W-1:0]   wr_addr;
	logic [htw_pkg::IVL_W-1:0]  divisor;
	logic [htw_pkg::TMO_W-1:0]  quo;
	logic [htw_pkg::TMO_W-1:0]  ticks;
	logic [htw_pkg::SLOT_W-1:0] new_slot;
	logic [htw_pkg::RND_W-1:0]  new_rnd;
	logic                       div_done;
	logic                       out_free;
	logic                       emit;

	assign rd_ent  = htw_pkg::entry_t'(rd_raw);
	// a zero interval divides as one
	assign divisor = (ivl_q == '0) ? htw_pkg::IVL_W'(1) : ivl_q;

	htw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (cmd.div_src_period ? rd_ent.period : tmo_q),
		.divisor  (divisor),
		.quo      (quo),
		.done     (div_done)
	);

	// timeout below one interval gives a quotient of zero, which counts as one tick
	assign ticks    = (quo == '0) ? htw_pkg::TMO_W'(1) : quo;
	assign new_slot = cur_q + ticks[htw_pkg::SLOT_W-1:0];
	assign new_rnd  = ticks[htw_pkg::TMO_W-1:htw_pkg::SLOT_W];

	always_comb begin
		wr_ent  = rd_ent;
		wr_addr = t_q;
		wr_en   = cmd.wr_start || cmd.wr_dec || cmd.wr_rearm;
		if (cmd.wr_start) begin
			wr_addr       = id_q;
			wr_ent.slot   = new_slot;
			wr_ent.rounds = new_rnd;
			wr_ent.per    = per_q;
			wr_ent.period = tmo_q;
		end else if (cmd.wr_rearm) begin
			wr_ent.slot   = new_slot;
			// landing back in the current slot costs one round
			wr_ent.rounds = (ticks[htw_pkg::SLOT_W-1:0] == '0 && new_rnd != '0)
				? new_rnd - htw_pkg::RND_W'(1) : new_rnd;
		end else begin
			wr_ent.rounds = rd_ent.rounds - htw_pkg::RND_W'(1);
		end
	end

	htw_ram #(
		.WIDTH (EW),
		.DEPTH (htw_pkg::NUM_TIMERS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_ent),
		.rd_en   (cmd.ram_rd),
		.rd_addr (t_q),
		.rd_data (rd_raw)
	);

	assign out_free = !ov_q || out_ready;
	assign emit     = cmd.emit_ack || cmd.emit_mid || cmd.emit_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ivl_q    <= htw_pkg::IVL_RESET;
			armed_q  <= '0;
			t_q      <= '0;
			cur_q    <= '0;
			pend_v_q <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (cfg_wr) begin
				ivl_q <= cfg_data;
			end
			if (cmd.wr_start) begin
				armed_q[id_q] <= 1'b1;
			end
			if (cmd.arm_clr_in) begin
				armed_q[id_q] <= 1'b0;
			end
			if (cmd.arm_clr_t) begin
				armed_q[t_q] <= 1'b0;
			end
			if (cmd.t_clr) begin
				t_q <= '0;
			end else if (cmd.t_inc) begin
				t_q <= t_q + htw_pkg::ID_W'(1);
			end
			if (cmd.cur_inc) begin
				cur_q <= cur_q + htw_pkg::SLOT_W'(1);
			end
			if (cmd.pend_clr) begin
				pend_v_q <= 1'b0;
			end else if (cmd.pend_set) begin
				pend_v_q <= 1'b1;
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			id_q  <= in_id;
			tmo_q <= in_tmo;
			per_q <= in_per;
		end
		if (cmd.pend_set) begin
			pend_q <= t_q;
		end
		if (cmd.emit_ack) begin
			of_q  <= 1'b0;
			oid_q <= '0;
			ol_q  <= 1'b1;
		end else if (cmd.emit_mid) begin
			of_q  <= 1'b1;
			oid_q <= pend_q;
			ol_q  <= 1'b0;
		end else if (cmd.emit_final) begin
			of_q  <= pend_v_q;
			oid_q <= pend_v_q ? pend_q : '0;
			ol_q  <= 1'b1;
		end
	end

	assign sts.in_op      = in_op;
	assign sts.armed_t    = armed_q[t_q];
	assign sts.slot_match = rd_ent.slot == cur_q;
	assign sts.rounds_nz  = rd_ent.rounds != '0;
	assign sts.periodic   = rd_ent.per;
	assign sts.div_done   = div_done;
	assign sts.out_free   = out_free;
	assign sts.t_last     = t_q == htw_pkg::ID_W'(htw_pkg::NUM_TIMERS - 1);
	assign sts.pend_valid = pend_v_q;

	assign out_valid = ov_q;
	assign out_fired = of_q;
	assign out_id    = oid_q;
	assign out_last  = ol_q;

endmodule

@@ sim/htw_wheel_checker.sv @@
// watches the wheel channels, predicts the fired ids and compares them
`timescale 1ns / 1ps

module htw_wheel_checker
	import htw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	htw_req_if   req,
	htw_rsp_if   rsp,
	htw_cfg_if   cfg,
	output int   mismatches,
	output int   outstanding
);

	typedef struct {
		logic            fired;
		logic [ID_W-1:0] fired_id;
		logic            last;
	} fire_rec_t;

	fire_rec_t         fire_q[$];
	logic [IVL_W-1:0]  ivl;
	logic              armed[NUM_TIMERS];
	logic [SLOT_W-1:0] slot_of[NUM_TIMERS];
	logic [RND_W-1:0]  rounds[NUM_TIMERS];
	logic              per_of[NUM_TIMERS];
	logic [TMO_W-1:0]  period_of[NUM_TIMERS];
	logic [SLOT_W-1:0] cur_slot;

	function automatic void arm_timer(int t, logic [TMO_W-1:0] tmo);
		int unsigned div;
		int unsigned ticks;
		div   = (ivl == 0) ? 1 : ivl;
		ticks = (tmo < div) ? 1 : tmo / div;
		rounds[t]  = RND_W'(ticks / SLOTS);
		slot_of[t] = SLOT_W'(cur_slot + ticks);
		armed[t]   = 1'b1;
	endfunction

	function automatic void push_fire(logic f, logic [ID_W-1:0] id, logic l);
		fire_rec_t r;
		r.fired    = f;
		r.fired_id = id;
		r.last     = l;
		fire_q.push_back(r);
	endfunction

	function automatic void predict_wheel(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
			logic [TMO_W-1:0] tmo, logic per);
		int n;
		n = 0;
		if (op == OP_START) begin
			per_of[id]    = per;
			period_of[id] = tmo;
			arm_timer(id, tmo);
		end else if (op == OP_REMOVE) begin
			armed[id] = 1'b0;
		end else if (op == OP_TICK) begin
			for (int t = 0; t < NUM_TIMERS; t++) begin
				if (!armed[t] || slot_of[t] != cur_slot)
					continue;
				if (rounds[t] != 0) begin
					rounds[t]--;
					continue;
				end
				push_fire(1'b1, ID_W'(t), 1'b0);
				n++;
				if (!per_of[t]) begin
					armed[t] = 1'b0;
				end else begin
					arm_timer(t, period_of[t]);
					if (slot_of[t] == cur_slot && rounds[t] != 0)
						rounds[t]--;
				end
			end
			cur_slot++;
		end
		if (n == 0)
			push_fire(1'b0, '0, 1'b1);
		else
			fire_q[$].last = 1'b1;
	endfunction

	function automatic void flag(string what);
		if (mismatches < 10)
			$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fire_rec_t e;
		if (!arst_n) begin
			ivl        = IVL_RESET;
			cur_slot   = '0;
			mismatches = 0;
			fire_q.delete();
			foreach (armed[t])
				armed[t] = 1'b0;
		end else begin
			if (cfg.valid && cfg.ready)
				ivl = cfg.data;
			if (req.valid && req.ready)
				predict_wheel(req.op, req.timer_id, req.timeout, req.periodic);
			if (rsp.valid && rsp.ready) begin
				if (fire_q.size() == 0) begin
					flag($sformatf("unexpected transfer fired=%0b id=%0d last=%0b",
						rsp.fired, rsp.fired_id, rsp.last));
				end else begin
					e = fire_q.pop_front();
					if (rsp.fired !== e.fired || rsp.fired_id !== e.fired_id
							|| rsp.last !== e.last)
						flag($sformatf("exp fired=%0b id=%0d last=%0b, got %0b %0d %0b",
							e.fired, e.fired_id, e.last, rsp.fired, rsp.fired_id,
							rsp.last));
				end
			end
		end
		outstanding = fire_q.size();
	end

endmodule

@@ sim/tb_hashed_timing_wheel.sv @@
// stimulus and verdict for the hashed timing wheel
`timescale 1ns / 1ps

module tb_hashed_timing_wheel;
	import htw_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 3000000;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   cycles;
	logic rsp_hold;

	htw_req_if req ();
	htw_rsp_if rsp ();
	htw_cfg_if cfg ();

	hashed_timing_wheel i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	htw_wheel_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg         (cfg),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("hashed_timing_wheel test failed");
			$finish;
		end
	end

	// result side: random stalls, and one long hold-off on request
	initial begin
		int n;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rsp_hold) begin
				rsp.ready <= 1'b0;
				repeat (400) @(posedge clk);
				rsp_hold = 1'b0;
			end
			n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
			if (n > 0) begin
				rsp.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!(rsp.valid && rsp.ready));
		end
	end

	task automatic send_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
			logic [TMO_W-1:0] tmo, logic per);
		int n;
		n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
		if (n > 0) begin
			req.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		req.valid    <= 1'b1;
		req.op       <= op;
		req.timer_id <= id;
		req.timeout  <= tmo;
		req.periodic <= per;
		do @(posedge clk); while (!req.ready);
	endtask

	// let all results drain and the scan settle before touching the interval
	task automatic drain();
		req.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_interval(logic [IVL_W-1:0] v);
		cfg.valid <= 1'b1;
		cfg.data  <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	task automatic random_phase(int count, int unsigned ivl);
		int unsigned r;
		int unsigned hi;
		logic [OP_W-1:0] op;
		logic [TMO_W-1:0] tmo;
		logic [ID_W-1:0] id;
		hi = (ivl * 30 > 1048575) ? 1048575 : ivl * 30;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 52) op = OP_TICK;
			else if (r < 82) op = OP_START;
			else if (r < 97) op = OP_REMOVE;
			else op = OP_UNUSED;
			tmo = ($urandom_range(0, 4) == 0) ? TMO_W'($urandom) : TMO_W'($urandom_range(0, hi));
			id  = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 15));
			if (i == count / 2 && ivl == 1)
				rsp_hold = 1'b1;
			send_item(op, id, tmo, 1'($urandom));
		end
	endtask

	initial begin
		rsp_hold     = 1'b0;
		cycles       = 0;
		arst_n       = 1'b0;
		req.valid    = 1'b0;
		req.op       = OP_TICK;
		req.timer_id = '0;
		req.timeout  = '0;
		req.periodic = 1'b0;
		cfg.valid    = 1'b0;
		cfg.data     = IVL_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, re-arm of an active timer, idle remove, unused op
		send_item(OP_START, 6'd0, 20'd0, 1'b0);
		send_item(OP_START, 6'd63, 20'hFFFFF, 1'b1);
		send_item(OP_START, 6'd5, 20'd1, 1'b1);
		send_item(OP_START, 6'd9, 20'd1024, 1'b1);
		send_item(OP_START, 6'd42, 20'd3, 1'b0);
		send_item(OP_REMOVE, 6'd20, 20'd0, 1'b0);
		send_item(OP_UNUSED, 6'd63, 20'hFFFFF, 1'b1);
		repeat (4) send_item(OP_TICK, 6'd0, 20'd0, 1'b0);
		send_item(OP_START, 6'd5, 20'd2, 1'b1);
		send_item(OP_START, 6'd0, 20'd2, 1'b0);
		send_item(OP_START, 6'd0, 20'd1, 1'b1);
		send_item(OP_REMOVE, 6'd5, 20'd0, 1'b0);
		send_item(OP_REMOVE, 6'd63, 20'd0, 1'b0);
		repeat (4) send_item(OP_TICK, 6'd0, 20'd0, 1'b0);
		send_item(OP_REMOVE, 6'd0, 20'd0, 1'b0);
		drain();

		random_phase(110, 1);
		drain();
		write_interval(16'hFFFF);
		random_phase(80, 65535);
		drain();
		write_interval(16'd37);
		random_phase(80, 37);
		drain();
		write_interval(16'd1);
		random_phase(80, 1);
		drain();

		if (mismatches == 0)
			$display("hashed_timing_wheel test passed");
		else
			$display("hashed_timing_wheel test failed");
		$finish;
	end

endmodule
